### hw/rtl/cms_pkg.sv
// ============================================================================
// cms_pkg: shared types and constants for the completion match scorer
// Holds the transaction payload structs, opcodes, modes, scoring constants and the case-fold and boundary helpers.
// ============================================================================
package cms_pkg;

    localparam int MAX_QUERY_DEF = 32;
    localparam int MAX_LABEL_DEF = 64;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_LABEL  = 2'd2;
    localparam logic [1:0] OP_END    = 2'd3;

    localparam logic [1:0] MODE_PREFIX = 2'd0;
    localparam logic [1:0] MODE_SUBSEQ = 2'd1;
    localparam logic [1:0] MODE_FUZZY  = 2'd2;

    localparam logic [10:0] SCORE_CAP = 11'd2047;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic signed [11:0] score;
        logic               truncated;
    } out_item_t;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
        return r;
    endfunction

    function automatic logic is_boundary(input logic [7:0] p, input logic [7:0] c);
        logic b;
        b = (p == 8'h00) || (p == 8'h5F) || (p == 8'h3A) || (p == 8'h2E)
            || (p == 8'h2D) || (p == 8'h20)
            || ((p >= 8'h61 && p <= 8'h7A) && (c >= 8'h41 && c <= 8'h5A));
        return b;
    endfunction

endpackage

### hw/rtl/cms_ram.sv
// ============================================================================
// cms_ram: generic single-write, single-read synchronous RAM
// One write port and one read port with the read data registered.
// ============================================================================
module cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/cms_lane_unit.sv
// ============================================================================
// cms_lane_unit: one scan lane step
// Given a lane's state, the query character it waits for and the label
// character, computes the lane's next index, score and adjacency.
// ============================================================================
module cms_lane_unit #(
    parameter int QW = 6,
    parameter int PW = 7
) (
    input  logic [QW-1:0] ni,
    input  logic [10:0]   lscore,
    input  logic          adj,
    input  logic          active,
    input  logic [7:0]    c,
    input  logic [7:0]    n,
    input  logic [7:0]    prev,
    input  logic [PW-1:0] li,
    output logic [QW-1:0] ni_next,
    output logic [10:0]   lscore_next,
    output logic          adj_next
);

    logic [5:0]  add;
    logic [11:0] sum;
    logic        hit;

    always_comb
    begin
        hit = (cms_pkg::fold(c) == cms_pkg::fold(n));
        add = 6'd10;
        if (adj) add = add + 6'd8;
        if (cms_pkg::is_boundary(prev, c)) add = add + 6'd12;
        if (li < PW'(4)) add = add + {2'b00, 3'd4 - li[2:0], 1'b0};
        if (c == n) add = add + 6'd1;
        sum = {1'b0, lscore} + {6'd0, add};
        ni_next = ni;
        lscore_next = lscore;
        adj_next = adj;
        if (active)
        begin
            if (hit)
            begin
                ni_next = ni + QW'(1);
                lscore_next = sum[11] ? cms_pkg::SCORE_CAP : sum[10:0];
                adj_next = 1'b1;
            end
            else
            begin
                adj_next = 1'b0;
            end
        end
    end

endmodule

### hw/rtl/completion_match_scorer.sv
// ============================================================================
// completion_match_scorer: query-based completion label scorer
// Scores streamed labels against a stored query in prefix, subsequence or
// one-skip fuzzy mode, with lane state kept in a synchronous memory.
// ============================================================================
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid/ready   | opcode, char_code
// out     | output    | out_valid/ready  | score, truncated
// cfg     | input     | cfg_we (no wait) | match_mode
//
// For a label character, each lane in turn is read, its query byte fetched and
// the lane written back, after the accept step and before a prefix step. A label
// end reads and reduces each lane in turn, forms the result in a result step and
// then sweeps all lanes clear. Query clears and appends run that clear sweep
// after the accept; a label character past capacity is only accepted. After
// reset a clearing pass over all lanes runs before the first transaction is
// taken. The result register waits for out_ready; input is still accepted, and
// only the next label end holds in its result step until the register is free.
module completion_match_scorer #(
    parameter int MAX_QUERY = cms_pkg::MAX_QUERY_DEF,
    parameter int MAX_LABEL = cms_pkg::MAX_LABEL_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cms_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cms_pkg::out_item_t  out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_data
);

    localparam int LANES = MAX_QUERY + 1;
    localparam int LW = $clog2(LANES);
    localparam int QW = $clog2(MAX_QUERY + 1);
    localparam int QA = $clog2(MAX_QUERY);
    localparam int PW = $clog2(MAX_LABEL + 1);
    localparam int LSW = QW + 11 + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLEAR = 6'b000010,
        S_RD    = 6'b000100,
        S_QRD   = 6'b001000,
        S_WR    = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0]    mode_reg;
    logic [QW-1:0] qlen_reg, qlen_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    prev_reg, prev_next;
    logic          pok_reg, pok_next, pcase_reg, pcase_next;
    logic          ovf_reg, ovf_next, cut_reg, cut_next;
    logic [LW-1:0] lane_reg, lane_next;
    logic          is_end_reg, is_end_next;
    logic [7:0]    ch_reg, ch_next;
    logic [QW-1:0] src_reg, src_next;
    logic          act_reg, act_next;
    logic signed [12:0] best_reg, best_next;
    logic          ovalid_reg, ovalid_next;
    cms_pkg::out_item_t odata_reg, odata_next;

    // Lane memory: {index, score, adjacent}.
    logic            lm_we;
    logic [LW-1:0]   lm_waddr, lm_raddr;
    logic [LSW-1:0]  lm_wdata, lm_rdata;
    // Query memory.
    logic            qm_we;
    logic [QA-1:0]   qm_waddr, qm_raddr;
    logic [7:0]      qm_rdata;

    cms_ram #(.WIDTH(LSW), .DEPTH(LANES)) u_lane_ram (
        .clk(clk), .we(lm_we), .waddr(lm_waddr), .wdata(lm_wdata),
        .raddr(lm_raddr), .rdata(lm_rdata)
    );

    cms_ram #(.WIDTH(8), .DEPTH(MAX_QUERY)) u_query_ram (
        .clk(clk), .we(qm_we), .waddr(qm_waddr), .wdata(in_data.char_code),
        .raddr(qm_raddr), .rdata(qm_rdata)
    );

    logic [QW-1:0] l_ni, u_ni;
    logic [10:0]   l_sc, u_sc;
    logic          l_adj, u_adj;
    logic [QW-1:0] target;
    logic          is_full;
    logic [QW-1:0] src_c;

    assign l_ni  = lm_rdata[LSW-1 -: QW];
    assign l_sc  = lm_rdata[11:1];
    assign l_adj = lm_rdata[0];
    assign is_full = (lane_reg == LW'(MAX_QUERY));

    cms_lane_unit #(.QW(QW), .PW(PW)) u_lane (
        .ni(l_ni), .lscore(l_sc), .adj(l_adj), .active(act_reg),
        .c(ch_reg), .n(qm_rdata), .prev(prev_reg), .li(pos_reg),
        .ni_next(u_ni), .lscore_next(u_sc), .adj_next(u_adj)
    );

    // Lane result terms.
    logic signed [12:0] lane_res;
    logic [PW:0]        pen;
    logic signed [12:0] diff;

    always_comb
    begin
        target = is_full ? qlen_reg : (qlen_reg - QW'(1));
        src_c  = (!is_full && (l_ni >= QW'(lane_reg))) ? (l_ni + QW'(1)) : l_ni;
        pen    = (PW+1)'(({1'b0, pos_reg} - {1'b0, PW'(target)}) >> 2);
        diff   = $signed({2'b00, l_sc}) - $signed(13'(pen));
        if (l_ni != target) lane_res = -13'sd1;
        else if (diff < 0) lane_res = 13'sd0;
        else lane_res = diff;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    always_comb
    begin
        state_next = state_reg;
        qlen_next = qlen_reg;
        pos_next = pos_reg;
        prev_next = prev_reg;
        pok_next = pok_reg;
        pcase_next = pcase_reg;
        ovf_next = ovf_reg;
        cut_next = cut_reg;
        lane_next = lane_reg;
        is_end_next = is_end_reg;
        ch_next = ch_reg;
        src_next = src_reg;
        act_next = act_reg;
        best_next = best_reg;
        ovalid_next = ovalid_reg;
        odata_next = odata_reg;
        lm_we = 1'b0;
        lm_waddr = lane_reg;
        lm_wdata = '0;
        lm_raddr = lane_reg;
        qm_we = 1'b0;
        qm_waddr = QA'(qlen_reg);
        qm_raddr = QA'(src_reg);
        if (ovalid_reg && out_ready) ovalid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    ch_next = in_data.char_code;
                    lane_next = '0;
                    case (in_data.opcode)
                        cms_pkg::OP_CLEAR:
                        begin
                            qlen_next = '0;
                            ovf_next = 1'b0;
                            state_next = S_CLEAR;
                        end
                        cms_pkg::OP_APPEND:
                        begin
                            if (qlen_reg < QW'(MAX_QUERY))
                            begin
                                qm_we = 1'b1;
                                qlen_next = qlen_reg + QW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                            state_next = S_CLEAR;
                        end
                        cms_pkg::OP_LABEL:
                        begin
                            if (pos_reg >= PW'(MAX_LABEL))
                            begin
                                cut_next = 1'b1;
                            end
                            else
                            begin
                                is_end_next = 1'b0;
                                best_next = -13'sd1;
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            is_end_next = 1'b1;
                            best_next = -13'sd1;
                            state_next = S_RD;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                lm_we = 1'b1;
                lm_wdata = '0;
                if (lane_reg == LW'(MAX_QUERY))
                begin
                    pos_next = '0;
                    prev_next = '0;
                    pok_next = 1'b1;
                    pcase_next = 1'b1;
                    cut_next = 1'b0;
                    lane_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    lane_next = lane_reg + LW'(1);
                end
            end
            S_RD:
            begin
                // Lane memory read is issued here; data arrives in S_QRD.
                state_next = S_QRD;
            end
            S_QRD:
            begin
                src_next = src_c;
                act_next = (is_full || (QW'(lane_reg) < qlen_reg)) && (l_ni < target)
                           && (src_c < QW'(MAX_QUERY));
                if (is_end_reg)
                begin
                    if (!is_full && (QW'(lane_reg) < qlen_reg) && lane_res >= 0
                        && (lane_res - 13'sd50) > best_reg)
                    begin
                        best_next = lane_res - 13'sd50;
                    end
                    if (is_full) state_next = S_DONE;
                    else
                    begin
                        lane_next = lane_reg + LW'(1);
                        state_next = S_RD;
                    end
                end
                else
                begin
                    // Query byte read for this lane; lane data held in the RAM
                    // output register until written back.
                    qm_raddr = QA'(src_c);
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                lm_we = 1'b1;
                lm_wdata = {u_ni, u_sc, u_adj};
                if (is_full)
                begin
                    if (pos_reg < PW'(qlen_reg) && pos_reg < PW'(MAX_QUERY))
                    begin
                        qm_raddr = QA'(pos_reg);
                    end
                    lane_next = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    lane_next = lane_reg + LW'(1);
                    state_next = S_RD;
                end
            end
            S_DONE:
            begin
                if (is_end_reg)
                begin
                    // The full-query lane stays on the memory output while
                    // the previous result is still waiting.
                    if (!ovalid_reg || out_ready)
                    begin
                        odata_next.truncated = ovf_reg || cut_reg;
                        case (mode_reg)
                            cms_pkg::MODE_PREFIX:
                            begin
                                if (qlen_reg == '0) odata_next.score = 12'sd0;
                                else if (pos_reg < PW'(qlen_reg) || !pok_reg)
                                    odata_next.score = -12'sd1;
                                else
                                    odata_next.score = 12'(13'sd1000
                                        + 13'(qlen_reg) * 13'sd10
                                        + (pcase_reg ? 13'sd50 : 13'sd0)
                                        + ((pos_reg == PW'(qlen_reg)) ? 13'sd100
                                                                     : 13'sd0));
                            end
                            cms_pkg::MODE_SUBSEQ:
                            begin
                                if (qlen_reg == '0) odata_next.score = 12'sd0;
                                else odata_next.score = 12'(lane_res);
                            end
                            cms_pkg::MODE_FUZZY:
                            begin
                                if (qlen_reg == '0) odata_next.score = 12'sd5;
                                else if (lane_res >= 0)
                                    odata_next.score = 12'(lane_res + 13'sd5);
                                else if (qlen_reg < QW'(3))
                                    odata_next.score = -12'sd1;
                                else odata_next.score = 12'(best_reg);
                            end
                            default: odata_next.score = -12'sd1;
                        endcase
                        ovalid_next = 1'b1;
                        lane_next = '0;
                        state_next = S_CLEAR;
                    end
                end
                else
                begin
                    // Query byte at pos_reg was read in S_WR for the prefix test.
                    if (pos_reg < PW'(qlen_reg) && pos_reg < PW'(MAX_QUERY))
                    begin
                        if (cms_pkg::fold(ch_reg) != cms_pkg::fold(qm_rdata))
                            pok_next = 1'b0;
                        if (ch_reg != qm_rdata) pcase_next = 1'b0;
                    end
                    prev_next = ch_reg;
                    pos_next = pos_reg + PW'(1);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            mode_reg   <= cms_pkg::MODE_FUZZY;
            qlen_reg   <= '0;
            pos_reg    <= '0;
            prev_reg   <= '0;
            pok_reg    <= 1'b1;
            pcase_reg  <= 1'b1;
            ovf_reg    <= 1'b0;
            cut_reg    <= 1'b0;
            lane_reg   <= '0;
            is_end_reg <= 1'b0;
            act_reg    <= 1'b0;
            best_reg   <= -13'sd1;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            if (cfg_we) mode_reg <= cfg_data;
            qlen_reg   <= qlen_next;
            pos_reg    <= pos_next;
            prev_reg   <= prev_next;
            pok_reg    <= pok_next;
            pcase_reg  <= pcase_next;
            ovf_reg    <= ovf_next;
            cut_reg    <= cut_next;
            lane_reg   <= lane_next;
            is_end_reg <= is_end_next;
            act_reg    <= act_next;
            best_reg   <= best_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg    <= ch_next;
        src_reg   <= src_next;
        odata_reg <= odata_next;
    end

endmodule

### tb/completion_match_scorer_test.sv
// ============================================================================
// completion_match_scorer_test: self-checking bench for the match scorer
// Streams queries and labels through the block in every match mode, predicts
// each label score and cut flag, and compares every result in order.
// ============================================================================
`timescale 1ns / 1ps

module completion_match_scorer_test;

    localparam int NQ = cms_pkg::MAX_QUERY_DEF;
    localparam int NL = cms_pkg::MAX_LABEL_DEF;

    typedef struct {
        logic [11:0] score;
        logic        truncated;
    } label_result_t;

    class score_board;
        logic [1:0]  mode;
        logic [7:0]  qchars[NQ];
        int          qlen;
        int          lpos;
        logic [7:0]  prev;
        int          lidx[NQ + 1];
        int          lsc[NQ + 1];
        bit          ladj[NQ + 1];
        bit          pok;
        bit          pcase;
        bit          qcut;
        bit          lcut;
        label_result_t pending[$];
        int          errors;

        function void reset_all();
            mode = cms_pkg::MODE_FUZZY;
            qlen = 0;
            qcut = 0;
            errors = 0;
            foreach (qchars[i]) qchars[i] = 8'h00;
            restart_label();
        endfunction

        function void restart_label();
            lpos = 0;
            prev = 8'h00;
            pok = 1;
            pcase = 1;
            lcut = 0;
            foreach (lidx[i])
            begin
                lidx[i] = 0;
                lsc[i] = 0;
                ladj[i] = 0;
            end
        endfunction

        function logic [7:0] lower(logic [7:0] c);
            return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        endfunction

        function bit starts_word(logic [7:0] p, logic [7:0] c);
            if (p == 8'h00 || p == "_" || p == ":" || p == "." || p == "-" || p == " ")
                return 1;
            return (p >= "a" && p <= "z") && (c >= "A" && c <= "Z");
        endfunction

        function int lane_final(int k, int tgt);
            int s;
            if (lidx[k] != tgt) return -1;
            s = lsc[k] - (lpos - tgt) / 4;
            return s < 0 ? 0 : s;
        endfunction

        function int final_score();
            int s;
            int best;
            case (mode)
                cms_pkg::MODE_PREFIX:
                begin
                    if (qlen == 0) return 0;
                    if (lpos < qlen || !pok) return -1;
                    s = 1000 + qlen * 10;
                    if (pcase) s += 50;
                    if (lpos == qlen) s += 100;
                    return s;
                end
                cms_pkg::MODE_SUBSEQ:
                begin
                    if (qlen == 0) return 0;
                    return lane_final(NQ, qlen);
                end
                cms_pkg::MODE_FUZZY:
                begin
                    if (qlen == 0) return 5;
                    s = lane_final(NQ, qlen);
                    if (s >= 0) return s + 5;
                    if (qlen < 3) return -1;
                    best = -1;
                    for (int k = 0; k < qlen; k++)
                    begin
                        s = lane_final(k, qlen - 1);
                        if (s >= 0 && s - 50 > best) best = s - 50;
                    end
                    return best;
                end
                default: return -1;
            endcase
        endfunction

        function void scan_char(logic [7:0] c);
            int tgt;
            int src;
            int add;
            if (lpos >= NL)
            begin
                lcut = 1;
                return;
            end
            if (lpos < qlen)
            begin
                if (lower(c) != lower(qchars[lpos])) pok = 0;
                if (c != qchars[lpos]) pcase = 0;
            end
            for (int k = 0; k <= NQ; k++)
            begin
                if (k == NQ) tgt = qlen;
                else if (k < qlen) tgt = qlen - 1;
                else continue;
                if (lidx[k] >= tgt) continue;
                src = (k < NQ && lidx[k] >= k) ? lidx[k] + 1 : lidx[k];
                if (src >= NQ) continue;
                if (lower(c) == lower(qchars[src]))
                begin
                    add = 10;
                    if (ladj[k]) add += 8;
                    if (starts_word(prev, c)) add += 12;
                    if (lpos < 4) add += (4 - lpos) * 2;
                    if (c == qchars[src]) add += 1;
                    lsc[k] += add;
                    if (lsc[k] > 2047) lsc[k] = 2047;
                    lidx[k]++;
                    ladj[k] = 1;
                end
                else
                    ladj[k] = 0;
            end
            prev = c;
            lpos++;
        endfunction

        function void note_input(cms_pkg::in_item_t t);
            label_result_t r;
            case (t.opcode)
                cms_pkg::OP_CLEAR:
                begin
                    qlen = 0;
                    qcut = 0;
                    restart_label();
                end
                cms_pkg::OP_APPEND:
                begin
                    if (qlen < NQ)
                    begin
                        qchars[qlen] = t.char_code;
                        qlen++;
                    end
                    else
                        qcut = 1;
                    restart_label();
                end
                cms_pkg::OP_LABEL: scan_char(t.char_code);
                default:
                begin
                    r.score = 12'(final_score());
                    r.truncated = qcut | lcut;
                    pending = {pending, r};
                    restart_label();
                end
            endcase
        endfunction

        function void check_result(cms_pkg::out_item_t o);
            label_result_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result score=%0d trunc=%0b", o.score, o.truncated);
                return;
            end
            e = pending.pop_front();
            if (o.score !== e.score || o.truncated !== e.truncated)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected score=%0d trunc=%0b, got score=%0d trunc=%0b",
                             $signed(e.score), e.truncated, o.score, o.truncated);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    cms_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 0;
    cms_pkg::out_item_t out_data;
    logic cfg_we = 0;
    logic [1:0] cfg_data = '0;

    int send_idle = 12;
    int recv_idle = 48;
    bit hold_off = 0;
    score_board sb;

    completion_match_scorer dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    // Receiver: random ready, forced low during the long hold-off.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_data);
        out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end

    // Valid stays high after acceptance until the next transaction or an idle
    // cycle replaces it in a later step.
    task automatic send(logic [1:0] op, logic [7:0] c);
        cms_pkg::in_item_t t;
        t.opcode = op;
        t.char_code = c;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_data <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(t);
    endtask

    task automatic set_mode(logic [1:0] m);
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (3 * (NQ + 1) + 10) @(posedge clk);
        cfg_we <= 1;
        cfg_data <= m;
        sb.mode = m;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(7))
            0: return 8'($urandom_range(255));
            1: return 8'($urandom_range(90, 65));
            2: return 8'h5F;
            3: return 8'h00;
            default: return 8'($urandom_range(100, 97));
        endcase
    endfunction

    task automatic load_query(int n);
        send(cms_pkg::OP_CLEAR, 8'($urandom));
        for (int i = 0; i < n; i++) send(cms_pkg::OP_APPEND, pick_char());
    endtask

    // Sends a label built from the query with random edits, mostly well formed.
    task automatic send_label(int n);
        int j;
        j = 0;
        for (int i = 0; i < n; i++)
        begin
            if (j < sb.qlen && $urandom_range(2) != 0)
            begin
                send(cms_pkg::OP_LABEL, $urandom_range(3) == 0 ? sb.qchars[j] ^ 8'h20
                                                                : sb.qchars[j]);
                j++;
            end
            else
                send(cms_pkg::OP_LABEL, pick_char());
        end
        send(cms_pkg::OP_END, 8'($urandom));
    endtask

    task automatic random_phase(int items);
        int sent;
        int ql;
        sent = 0;
        while (sent < items)
        begin
            ql = $urandom_range(9) == 0 ? $urandom_range(NQ + 3) : $urandom_range(6);
            load_query(ql);
            sent += ql + 1;
            repeat ($urandom_range(4, 1))
            begin
                ql = $urandom_range(9) == 0 ? $urandom_range(NL + 4) : $urandom_range(10);
                if ($urandom_range(15) == 0)
                begin
                    send(cms_pkg::OP_LABEL, pick_char());
                    send(cms_pkg::OP_APPEND, pick_char());
                end
                send_label(ql);
                sent += ql + 1;
            end
        end
    endtask

    initial
    begin
        sb = new();
        sb.reset_all();
        repeat (11) @(posedge clk);
        rst_n <= 1;
        // Directed: empty query in every mode, including the unused one.
        for (int m = 0; m < 4; m++)
        begin
            set_mode(2'(m));
            send(cms_pkg::OP_END, 8'hFF);
        end
        set_mode(cms_pkg::MODE_PREFIX);
        load_query(3);
        send(cms_pkg::OP_LABEL, sb.qchars[0]);
        send(cms_pkg::OP_LABEL, sb.qchars[1]);
        send(cms_pkg::OP_LABEL, sb.qchars[2]);
        send(cms_pkg::OP_END, 8'h00);
        set_mode(cms_pkg::MODE_FUZZY);
        send(cms_pkg::OP_CLEAR, 8'h00);
        send(cms_pkg::OP_APPEND, "a");
        send(cms_pkg::OP_APPEND, "B");
        send(cms_pkg::OP_APPEND, "c");
        send(cms_pkg::OP_LABEL, "x");
        send(cms_pkg::OP_LABEL, "_");
        send(cms_pkg::OP_LABEL, "A");
        send(cms_pkg::OP_LABEL, "c");
        send(cms_pkg::OP_END, 8'h00);

        // Long hold-off on the receiver while labels keep coming.
        hold_off = 1;
        fork
            begin
                repeat (3000) @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 8; i++) send_label(2);
        join

        for (int p = 0; p < 3; p++)
        begin
            if (p == 1)
            begin
                send_idle = 48;
                recv_idle = 12;
            end
            if (p == 2)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int m = 0; m < 3; m++)
            begin
                set_mode(2'(m));
                random_phase(80);
            end
        end
        set_mode(2'd3);
        random_phase(20);

        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (2 * (NQ + 1) + 20) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
